[hdl/psd_pkg.sv]
// Shared types, codes and constants of the polygon signed distance block.
package psd_pkg;

   localparam int DEF_MAX_VERTICES = 64;
   localparam int COORD_W          = 16;
   localparam int DIST_W           = 18;
   localparam int EDGE_IDX_W       = 6;
   localparam int STATUS_W         = 2;
   localparam int SQRT_BITS        = 18;
   localparam int SQRT_BIT_W       = 5;

   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_STORED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_VALID  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

   typedef enum logic [1:0] {
      RSP_NONE,
      RSP_APPEND,
      RSP_EMPTY,
      RSP_DIST
   } rsp_op_type;

   typedef enum logic [1:0] {
      SQ_NONE,
      SQ_SQUARE,
      SQ_SCALE,
      SQ_DECIDE
   } sq_op_type;

   typedef struct packed {
      logic                  load_req;
      logic                  append;
      logic                  rd_en;
      logic                  rd_edge;
      logic                  rd_first;
      logic                  rd_last;
      logic                  sq_clear;
      sq_op_type             sq_op;
      logic [SQRT_BIT_W-1:0] sq_bit;
      rsp_op_type            rsp_op;
   } psd_cmd_type;

   typedef struct packed {
      logic empty;
      logic walk_done;
   } psd_stat_type;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } edge_tag_type;

endpackage

[hdl/polygon_signed_distance.sv]
// Top level of the polygon signed distance block.
// Append: the vertex is written in the S_APPEND state and the result word is registered there.
// Query: the edge walk is paced by the nearest-edge compare loop, then the square
//   root runs a square, scale and decide step for each result bit.
// Empty query: no walk. One word in flight at a time; the receiver cannot stall.
// Reset clears the vertex count and control; the vertex store keeps old contents.
module polygon_signed_distance #(
   parameter int MAX_VERTICES = psd_pkg::DEF_MAX_VERTICES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic signed [psd_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [psd_pkg::COORD_W-1:0] req_point_y,
   output logic                               rsp_strobe,
   output logic [psd_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [psd_pkg::DIST_W-1:0]  rsp_signed_distance,
   output logic [psd_pkg::EDGE_IDX_W-1:0]     rsp_edge_start,
   output logic [psd_pkg::EDGE_IDX_W-1:0]     rsp_edge_end
);
   import psd_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   // command bundle from the sequencer, status bundle back
   psd_cmd_type   cmd;
   psd_stat_type  stat;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] vertex_count;

   // sequencer: accept word, walk edges (last,0),(0,1),..., run root, strobe result
   psd_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_type     (req_type),
      .stat         (stat),
      .vertex_count (vertex_count),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe)
   );

   // datapath: vertex store, distance pipeline, crossing parity, exact min, root
   psd_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .rd_addr             (rd_addr),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .stat                (stat),
      .vertex_count        (vertex_count),
      .rsp_status          (rsp_status),
      .rsp_signed_distance (rsp_signed_distance),
      .rsp_edge_start      (rsp_edge_start),
      .rsp_edge_end        (rsp_edge_end)
   );

endmodule

[hdl/psd_datapath.sv]
// Vertex store, edge distance pipeline, nearest edge tracking and square root unit.
module psd_datapath #(
   parameter int MAX_VERTICES = psd_pkg::DEF_MAX_VERTICES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  psd_pkg::psd_cmd_type                   cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0]        rd_addr,
   input  logic signed [psd_pkg::COORD_W-1:0]     req_point_x,
   input  logic signed [psd_pkg::COORD_W-1:0]     req_point_y,
   output psd_pkg::psd_stat_type                  stat,
   output logic [$clog2(MAX_VERTICES+1)-1:0]      vertex_count,
   output logic [psd_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [psd_pkg::DIST_W-1:0]      rsp_signed_distance,
   output logic [psd_pkg::EDGE_IDX_W-1:0]         rsp_edge_start,
   output logic [psd_pkg::EDGE_IDX_W-1:0]         rsp_edge_end
);
   import psd_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   // vertex store
   logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
   logic [CW-1:0]             count_ff;
   logic                      full;

   logic signed [COORD_W-1:0] px_ff, py_ff;

   // read stage and previous vertex
   logic signed [COORD_W-1:0] r_x_ff, r_y_ff, vb_x_ff, vb_y_ff;
   logic [AW-1:0]             r_idx_ff, vb_idx_ff;
   logic                      r_vld_ff, r_edge_ff, r_first_ff, r_last_ff;

   // difference stage
   edge_tag_type      d_tag_ff;
   logic [AW-1:0]     d_ia_ff, d_ib_ff;
   logic signed [16:0] d_dx_ff, d_dy_ff, d_wx_ff, d_wy_ff, d_ex_ff, d_ey_ff;
   logic              d_cross_ff, d_dpos_ff;

   // product stage
   edge_tag_type      m_tag_ff;
   logic [AW-1:0]     m_ia_ff, m_ib_ff;
   logic signed [33:0] m_wxdx_ff, m_wydy_ff, m_dxdx_ff, m_dydy_ff, m_wxdy_ff, m_wydx_ff;
   logic signed [33:0] m_wxwx_ff, m_wywy_ff, m_exex_ff, m_eyey_ff, m_exdy_ff, m_dxey_ff;
   logic              m_cross_ff, m_dpos_ff;
   logic              m_hit;

   // sum and select stage
   logic signed [34:0] s_dot, s_len2_w, s_cr, s_crm_w, s_pa_w, s_pb_w;
   edge_tag_type      s_tag_ff;
   logic [AW-1:0]     s_ia_ff, s_ib_ff;
   logic              s_perp_ff;
   logic [32:0]       s_pt_ff, s_len2_ff;
   logic [33:0]       s_crm_ff;
   logic              inside_ff;

   // squared distance stage
   edge_tag_type      q_tag_ff;
   logic [AW-1:0]     q_ia_ff, q_ib_ff;
   logic [67:0]       q_num_ff, q_sq;
   logic [32:0]       q_den_ff;

   // cross product stage against best
   edge_tag_type      p_tag_ff;
   logic [AW-1:0]     p_ia_ff, p_ib_ff;
   logic [67:0]       p_num_ff;
   logic [32:0]       p_den_ff;
   logic [66:0]       p_nl_ff, p_nh_ff, p_bl_ff, p_bh_ff;
   logic [100:0]      u_lhs, u_rhs;

   logic [67:0]       best_num_ff;
   logic [32:0]       best_den_ff;
   logic [AW-1:0]     best_ia_ff, best_ib_ff;

   // square root unit
   logic [SQRT_BITS-1:0]   root_ff, root_try;
   logic [2*SQRT_BITS-1:0] tsq_ff;
   logic [50:0]            sq_hi_ff, sq_lo_ff;
   logic [69:0]            sq_lhs;
   logic signed [DIST_W-1:0] dist_val;

   assign full         = (count_ff == CW'(MAX_VERTICES));
   assign vertex_count = count_ff;
   assign stat.empty     = (count_ff == '0);
   assign stat.walk_done = p_tag_ff.vld & p_tag_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.append && !full) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && !full) begin
         mem_x[count_ff[AW-1:0]] <= px_ff;
         mem_y[count_ff[AW-1:0]] <= py_ff;
      end
      if (cmd.rd_en) begin
         r_x_ff <= mem_x[rd_addr];
         r_y_ff <= mem_y[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         px_ff <= req_point_x;
         py_ff <= req_point_y;
      end
      r_idx_ff   <= rd_addr;
      r_edge_ff  <= cmd.rd_edge;
      r_first_ff <= cmd.rd_first;
      r_last_ff  <= cmd.rd_last;
      if (r_vld_ff) begin
         vb_x_ff   <= r_x_ff;
         vb_y_ff   <= r_y_ff;
         vb_idx_ff <= r_idx_ff;
      end
   end

   // edge from previous vertex (A) to just read vertex (B)
   always_ff @(posedge clock) begin
      d_ia_ff    <= vb_idx_ff;
      d_ib_ff    <= r_idx_ff;
      d_dx_ff    <= 17'(r_x_ff) - 17'(vb_x_ff);
      d_dy_ff    <= 17'(r_y_ff) - 17'(vb_y_ff);
      d_wx_ff    <= 17'(px_ff) - 17'(vb_x_ff);
      d_wy_ff    <= 17'(py_ff) - 17'(vb_y_ff);
      d_ex_ff    <= 17'(px_ff) - 17'(r_x_ff);
      d_ey_ff    <= 17'(py_ff) - 17'(r_y_ff);
      d_cross_ff <= (r_y_ff > py_ff) != (vb_y_ff > py_ff);
      d_dpos_ff  <= vb_y_ff > r_y_ff;

      m_ia_ff    <= d_ia_ff;
      m_ib_ff    <= d_ib_ff;
      m_wxdx_ff  <= d_wx_ff * d_dx_ff;
      m_wydy_ff  <= d_wy_ff * d_dy_ff;
      m_dxdx_ff  <= d_dx_ff * d_dx_ff;
      m_dydy_ff  <= d_dy_ff * d_dy_ff;
      m_wxdy_ff  <= d_wx_ff * d_dy_ff;
      m_wydx_ff  <= d_wy_ff * d_dx_ff;
      m_wxwx_ff  <= d_wx_ff * d_wx_ff;
      m_wywy_ff  <= d_wy_ff * d_wy_ff;
      m_exex_ff  <= d_ex_ff * d_ex_ff;
      m_eyey_ff  <= d_ey_ff * d_ey_ff;
      m_exdy_ff  <= d_ex_ff * d_dy_ff;
      m_dxey_ff  <= d_dx_ff * d_ey_ff;
      m_cross_ff <= d_cross_ff;
      m_dpos_ff  <= d_dpos_ff;
   end

   assign m_hit = m_cross_ff &
                  (m_dpos_ff ? (m_exdy_ff > m_dxey_ff) : (m_exdy_ff < m_dxey_ff));

   assign s_dot    = 35'(m_wxdx_ff) + 35'(m_wydy_ff);
   assign s_len2_w = 35'(m_dxdx_ff) + 35'(m_dydy_ff);
   assign s_cr     = 35'(m_wxdy_ff) - 35'(m_wydx_ff);
   assign s_crm_w  = s_cr[34] ? -s_cr : s_cr;
   assign s_pa_w   = 35'(m_wxwx_ff) + 35'(m_wywy_ff);
   assign s_pb_w   = 35'(m_exex_ff) + 35'(m_eyey_ff);

   always_ff @(posedge clock) begin
      s_ia_ff   <= m_ia_ff;
      s_ib_ff   <= m_ib_ff;
      s_len2_ff <= s_len2_w[32:0];
      s_crm_ff  <= s_crm_w[33:0];
      priority if (s_len2_w == '0 || s_dot <= 35'sd0) begin
         s_perp_ff <= 1'b0;
         s_pt_ff   <= s_pa_w[32:0];
      end else if (s_dot >= s_len2_w) begin
         s_perp_ff <= 1'b0;
         s_pt_ff   <= s_pb_w[32:0];
      end else begin
         s_perp_ff <= 1'b1;
         s_pt_ff   <= s_pa_w[32:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         inside_ff <= 1'b0;
      end else if (m_tag_ff.vld && m_hit) begin
         inside_ff <= ~inside_ff;
      end
   end

   assign q_sq = s_crm_ff * s_crm_ff;

   always_ff @(posedge clock) begin
      q_ia_ff  <= s_ia_ff;
      q_ib_ff  <= s_ib_ff;
      q_num_ff <= s_perp_ff ? q_sq : 68'(s_pt_ff);
      q_den_ff <= s_perp_ff ? s_len2_ff : 33'd1;

      p_ia_ff  <= q_ia_ff;
      p_ib_ff  <= q_ib_ff;
      p_num_ff <= q_num_ff;
      p_den_ff <= q_den_ff;
      p_nl_ff  <= q_num_ff[33:0] * best_den_ff;
      p_nh_ff  <= q_num_ff[67:34] * best_den_ff;
      p_bl_ff  <= best_num_ff[33:0] * q_den_ff;
      p_bh_ff  <= best_num_ff[67:34] * q_den_ff;
   end

   // keep the first minimum: replace only on strictly smaller
   assign u_lhs = {p_nh_ff, 34'b0} + 101'(p_nl_ff);
   assign u_rhs = {p_bh_ff, 34'b0} + 101'(p_bl_ff);

   always_ff @(posedge clock) begin
      if (p_tag_ff.vld && (p_tag_ff.first || u_lhs < u_rhs)) begin
         best_num_ff <= p_num_ff;
         best_den_ff <= p_den_ff;
         best_ia_ff  <= p_ia_ff;
         best_ib_ff  <= p_ib_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
         d_tag_ff <= '0;
         m_tag_ff <= '0;
         s_tag_ff <= '0;
         q_tag_ff <= '0;
         p_tag_ff <= '0;
      end else begin
         r_vld_ff <= cmd.rd_en;
         d_tag_ff <= '{vld: r_vld_ff & r_edge_ff, first: r_first_ff, last: r_last_ff};
         m_tag_ff <= d_tag_ff;
         s_tag_ff <= m_tag_ff;
         q_tag_ff <= s_tag_ff;
         p_tag_ff <= q_tag_ff;
      end
   end

   // bitwise root: largest r with r*r*den <= num
   assign root_try = root_ff | (SQRT_BITS'(1) << cmd.sq_bit);
   assign sq_lhs   = 70'({sq_hi_ff, 18'b0}) + 70'(sq_lo_ff);

   always_ff @(posedge clock) begin
      if (cmd.sq_clear) begin
         root_ff <= '0;
      end else begin
         unique case (cmd.sq_op)
            SQ_SQUARE: begin
               tsq_ff <= root_try * root_try;
            end
            SQ_SCALE: begin
               sq_hi_ff <= tsq_ff[35:18] * best_den_ff;
               sq_lo_ff <= tsq_ff[17:0] * best_den_ff;
            end
            SQ_DECIDE: begin
               if (sq_lhs <= 70'(best_num_ff)) begin
                  root_ff <= root_try;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign dist_val = inside_ff ? (DIST_W'(0) - DIST_W'(root_ff)) : DIST_W'(root_ff);

   always_ff @(posedge clock) begin
      unique case (cmd.rsp_op)
         RSP_APPEND: begin
            rsp_status          <= full ? ST_FULL : ST_STORED;
            rsp_signed_distance <= '0;
            rsp_edge_start      <= '0;
            rsp_edge_end        <= '0;
         end
         RSP_EMPTY: begin
            rsp_status          <= ST_EMPTY;
            rsp_signed_distance <= '0;
            rsp_edge_start      <= '0;
            rsp_edge_end        <= '0;
         end
         RSP_DIST: begin
            rsp_status          <= ST_VALID;
            rsp_signed_distance <= dist_val;
            rsp_edge_start      <= EDGE_IDX_W'(best_ia_ff);
            rsp_edge_end        <= EDGE_IDX_W'(best_ib_ff);
         end
         default: begin
         end
      endcase
   end

endmodule

[hdl/psd_ctrl.sv]
// Sequencer for append, edge walk, square root and result strobe.
module psd_ctrl #(
   parameter int MAX_VERTICES = psd_pkg::DEF_MAX_VERTICES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               req_type,
   input  psd_pkg::psd_stat_type              stat,
   input  logic [$clog2(MAX_VERTICES+1)-1:0]  vertex_count,
   output psd_pkg::psd_cmd_type               cmd,
   output logic [$clog2(MAX_VERTICES)-1:0]    rd_addr,
   output logic                               busy,
   output logic                               rsp_strobe
);
   import psd_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_APPEND,
      S_EMPTY,
      S_WALK,
      S_DRAIN,
      S_SQUARE,
      S_SCALE,
      S_DECIDE,
      S_RESULT
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         step_ff;
   logic                  phase_ff;
   logic [SQRT_BIT_W-1:0] bit_ff;
   logic                  busy_ff, strobe_ff;

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.append   = 1'b0;
      cmd.rd_en    = 1'b0;
      cmd.rd_edge  = 1'b0;
      cmd.rd_first = 1'b0;
      cmd.rd_last  = 1'b0;
      cmd.sq_clear = 1'b0;
      cmd.sq_op    = SQ_NONE;
      cmd.sq_bit   = bit_ff;
      cmd.rsp_op   = RSP_NONE;
      rd_addr      = (step_ff == '0) ? AW'(vertex_count - CW'(1)) : AW'(step_ff - CW'(1));
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               priority if (req_type == REQ_APPEND) begin
                  state_in = S_APPEND;
               end else if (stat.empty) begin
                  state_in = S_EMPTY;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            cmd.rsp_op = RSP_APPEND;
            state_in   = S_IDLE;
         end
         S_EMPTY: begin
            cmd.rsp_op = RSP_EMPTY;
            state_in   = S_IDLE;
         end
         S_WALK: begin
            // first read primes the last vertex, each later read closes an edge
            if (!phase_ff) begin
               cmd.rd_en    = 1'b1;
               cmd.rd_edge  = (step_ff != '0);
               cmd.rd_first = (step_ff == CW'(1));
               cmd.rd_last  = (step_ff == vertex_count);
               if (step_ff == vertex_count) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (stat.walk_done) begin
               cmd.sq_clear = 1'b1;
               state_in     = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.sq_op = SQ_SQUARE;
            state_in  = S_SCALE;
         end
         S_SCALE: begin
            cmd.sq_op = SQ_SCALE;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.sq_op = SQ_DECIDE;
            state_in  = (bit_ff == '0) ? S_RESULT : S_SQUARE;
         end
         S_RESULT: begin
            cmd.rsp_op = RSP_DIST;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         step_ff   <= '0;
         phase_ff  <= 1'b0;
         bit_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != S_IDLE);
         strobe_ff <= (cmd.rsp_op != RSP_NONE);
         if (state_ff == S_IDLE) begin
            step_ff  <= '0;
            phase_ff <= 1'b0;
         end else if (state_ff == S_WALK) begin
            phase_ff <= ~phase_ff;
            if (!phase_ff) begin
               step_ff <= step_ff + CW'(1);
            end
         end
         if (cmd.sq_clear) begin
            bit_ff <= SQRT_BIT_W'(SQRT_BITS - 1);
         end else if (state_ff == S_DECIDE && bit_ff != '0) begin
            bit_ff <= bit_ff - SQRT_BIT_W'(1);
         end
      end
   end

endmodule

[hdl/psd_checker.sv]
// Port level checks of the polygon signed distance block, bound to the top level.
module psd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               req_type,
   input logic signed [psd_pkg::COORD_W-1:0] req_point_x,
   input logic signed [psd_pkg::COORD_W-1:0] req_point_y,
   input logic                               rsp_strobe,
   input logic [psd_pkg::STATUS_W-1:0]       rsp_status,
   input logic signed [psd_pkg::DIST_W-1:0]  rsp_signed_distance,
   input logic [psd_pkg::EDGE_IDX_W-1:0]     rsp_edge_start,
   input logic [psd_pkg::EDGE_IDX_W-1:0]     rsp_edge_end
);
   import psd_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(busy))
      else $error("result word outside a busy period");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result words in a row");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_VALID |->
         rsp_signed_distance == '0 && rsp_edge_start == '0 && rsp_edge_end == '0)
      else $error("nonzero fields on a non-distance result");

endmodule

bind polygon_signed_distance psd_checker u_psd_checker (.*);

[test/polygon_signed_distance_check.sv]
// Checker for the polygon signed distance block: predicts and compares result words.
`timescale 1ns / 100ps
module polygon_signed_distance_check
   import psd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic                        req_type,
   input  logic signed [COORD_W-1:0]   req_point_x,
   input  logic signed [COORD_W-1:0]   req_point_y,
   input  logic                        rsp_strobe,
   input  logic [STATUS_W-1:0]         rsp_status,
   input  logic signed [DIST_W-1:0]    rsp_signed_distance,
   input  logic [EDGE_IDX_W-1:0]       rsp_edge_start,
   input  logic [EDGE_IDX_W-1:0]       rsp_edge_end,
   output int                          fail_count,
   output int                          words_pending
);

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DIST_W-1:0] distance;
      logic [EDGE_IDX_W-1:0]    e_start;
      logic [EDGE_IDX_W-1:0]    e_end;
   } dist_word_type;

   dist_word_type word_queue[$];
   longint     poly_x[DEF_MAX_VERTICES];
   longint     poly_y[DEF_MAX_VERTICES];
   int         poly_count;

   // squared distance to edge a-b as num/den
   function automatic void edge_dist2(input longint px, input longint py, input int a,
                                      input int b, output bit [127:0] num,
                                      output bit [127:0] den);
      longint dx, dy, wx, wy, dot, len2, cr, ex, ey;
      bit [63:0] m;
      dx = poly_x[b] - poly_x[a];
      dy = poly_y[b] - poly_y[a];
      wx = px - poly_x[a];
      wy = py - poly_y[a];
      ex = px - poly_x[b];
      ey = py - poly_y[b];
      dot = wx * dx + wy * dy;
      len2 = dx * dx + dy * dy;
      den = 1;
      if (len2 == 0 || dot <= 0) begin
         num = 128'(wx * wx + wy * wy);
      end else if (dot >= len2) begin
         num = 128'(ex * ex + ey * ey);
      end else begin
         cr = wx * dy - wy * dx;
         m = (cr < 0) ? 64'(-cr) : 64'(cr);
         num = 128'(m) * 128'(m);
         den = 128'(len2);
      end
   endfunction

   function automatic bit point_inside(input longint px, input longint py);
      bit in_poly;
      int j;
      longint d, lhs, rhs;
      in_poly = 0;
      j = poly_count - 1;
      for (int i = 0; i < poly_count; i++) begin
         if ((poly_y[i] > py) != (poly_y[j] > py)) begin
            d = poly_y[j] - poly_y[i];
            lhs = (px - poly_x[i]) * d;
            rhs = (poly_x[j] - poly_x[i]) * (py - poly_y[i]);
            if (d > 0 ? (lhs < rhs) : (lhs > rhs)) in_poly = !in_poly;
         end
         j = i;
      end
      return in_poly;
   endfunction

   function automatic dist_word_type predict_word(input logic kind, input longint px,
                                                  input longint py);
      dist_word_type w;
      bit [127:0] best_num, best_den, num, den, t;
      int best_a, best_b;
      bit [17:0] mag;
      w = '0;
      if (kind == REQ_APPEND) begin
         if (poly_count < DEF_MAX_VERTICES) begin
            poly_x[poly_count] = px;
            poly_y[poly_count] = py;
            poly_count++;
            w.status = ST_STORED;
         end else begin
            w.status = ST_FULL;
         end
         return w;
      end
      if (poly_count == 0) begin
         w.status = ST_EMPTY;
         return w;
      end
      // closing edge first, then walk; keep the first minimum
      best_a = poly_count - 1;
      best_b = 0;
      edge_dist2(px, py, best_a, best_b, best_num, best_den);
      for (int b = 1; b < poly_count; b++) begin
         edge_dist2(px, py, b - 1, b, num, den);
         if (num * best_den < best_num * den) begin
            best_num = num;
            best_den = den;
            best_a = b - 1;
            best_b = b;
         end
      end
      mag = 0;
      for (int k = 17; k >= 0; k--) begin
         t = 128'(mag | (18'd1 << k));
         if (t * t * best_den <= best_num) mag[k] = 1'b1;
      end
      w.status = ST_VALID;
      w.distance = point_inside(px, py) ? DIST_W'(-$signed({1'b0, mag}))
                                        : DIST_W'(mag);
      w.e_start = best_a[EDGE_IDX_W-1:0];
      w.e_end = best_b[EDGE_IDX_W-1:0];
      return w;
   endfunction

   always @(posedge clock) begin
      dist_word_type exp_w;
      if (reset) begin
         poly_count = 0;
         word_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (word_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: result word with none expected (status %0d)", rsp_status);
            end else begin
               exp_w = word_queue.pop_front();
               if (rsp_status !== exp_w.status || rsp_signed_distance !== exp_w.distance ||
                   rsp_edge_start !== exp_w.e_start || rsp_edge_end !== exp_w.e_end) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("ERROR: expected st %0d d %0d e %0d-%0d, got st %0d d %0d e %0d-%0d",
                              exp_w.status, exp_w.distance, exp_w.e_start, exp_w.e_end,
                              rsp_status, rsp_signed_distance, rsp_edge_start, rsp_edge_end);
               end
            end
         end
         if (start && !busy)
            word_queue.push_back(predict_word(req_type, req_point_x, req_point_y));
      end
      words_pending = word_queue.size();
   end

endmodule

[test/polygon_signed_distance_test.sv]
// Testbench top: stimulus, idling phases and verdict for the polygon signed distance block.
`timescale 1ns / 100ps
module polygon_signed_distance_test;
   import psd_pkg::*;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      start = 0;
   logic                      busy;
   logic                      req_type = REQ_APPEND;
   logic signed [COORD_W-1:0] req_point_x = '0;
   logic signed [COORD_W-1:0] req_point_y = '0;
   logic                      rsp_strobe;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [DIST_W-1:0]  rsp_signed_distance;
   logic [EDGE_IDX_W-1:0]     rsp_edge_start;
   logic [EDGE_IDX_W-1:0]     rsp_edge_end;
   int                        fail_count;
   int                        words_pending;

   // host-side copy of stored vertices, used to aim queries at corners
   int  vert_x[DEF_MAX_VERTICES];
   int  vert_y[DEF_MAX_VERTICES];
   int  vert_count = 0;
   int  query_count = 0;
   int  append_count = 0;
   int  idle_pct = 0;
   longint cycle_count = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   polygon_signed_distance DUT (
      .clock, .reset, .start, .busy, .req_type, .req_point_x, .req_point_y,
      .rsp_strobe, .rsp_status, .rsp_signed_distance, .rsp_edge_start, .rsp_edge_end
   );

   polygon_signed_distance_check checker_i (
      .clock, .reset, .start, .busy, .req_type, .req_point_x, .req_point_y,
      .rsp_strobe, .rsp_status, .rsp_signed_distance, .rsp_edge_start, .rsp_edge_end,
      .fail_count, .words_pending
   );

   // watchdog: the slowest run is well under this
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("polygon_signed_distance: mismatch");
         $finish;
      end
   end

   // Send one word; hold start until an edge accepts it. Call and return at a rising edge.
   task automatic send_word(input logic kind, input int px, input int py);
      bit taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_point_x <= px[COORD_W-1:0];
      req_point_y <= py[COORD_W-1:0];
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
      if (kind == REQ_QUERY) begin
         query_count++;
      end else begin
         append_count++;
         if (vert_count < DEF_MAX_VERTICES) begin
            vert_x[vert_count] = px;
            vert_y[vert_count] = py;
            vert_count++;
         end
      end
   endtask

   function automatic int clamp16(input real v);
      if (v > 32767.0) return 32767;
      if (v < -32768.0) return -32768;
      return int'(v);
   endfunction

   // Pick a query point: at a corner, inside a central box, or anywhere.
   task automatic send_query();
      int sel, k;
      sel = $urandom_range(99);
      if (sel < 15 && vert_count > 0) begin
         k = $urandom_range(vert_count - 1);
         send_word(REQ_QUERY, vert_x[k], vert_y[k]);
      end else if (sel < 70) begin
         send_word(REQ_QUERY, $signed($urandom_range(24000)) - 12000,
                   $signed($urandom_range(24000)) - 12000);
      end else begin
         send_word(REQ_QUERY, $signed(16'($urandom)), $signed(16'($urandom)));
      end
   endtask

   initial begin
      real ang, rad;
      int  item;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty polygon, single vertex, degenerate edge, field extremes
      send_word(REQ_QUERY, 0, 0);
      send_word(REQ_APPEND, 0, 0);
      send_word(REQ_QUERY, 100, -50);
      send_word(REQ_QUERY, 0, 0);
      send_word(REQ_APPEND, 0, 0);
      send_word(REQ_QUERY, -32768, 32767);
      send_word(REQ_APPEND, 32767, -32768);
      send_word(REQ_APPEND, -32768, -32768);
      send_word(REQ_QUERY, 32767, 32767);
      send_word(REQ_QUERY, -32768, -32768);
      send_word(REQ_QUERY, -1, -1);
      send_word(REQ_QUERY, -100, -20000);
      send_word(REQ_APPEND, -32768, 32767);
      send_word(REQ_QUERY, -5000, 0);
      send_word(REQ_QUERY, 32767, -32768);

      // random: grow a star-shaped outline with queries at every size, then
      // keep querying a full store and poke it with dropped appends
      for (item = 0; item < 1100; item++) begin
         case ((item / 137) % 4)
            0: idle_pct = 0;
            1: idle_pct = 66;
            2: idle_pct = 9;
            default: idle_pct = 0;
         endcase
         if (item == 550) begin
            // hold off until the block has drained every word
            start <= 1'b0;
            @(posedge clock);
            while (words_pending != 0) @(posedge clock);
         end
         if (vert_count < DEF_MAX_VERTICES ? $urandom_range(99) < 40
                                           : $urandom_range(99) < 8) begin
            if ($urandom_range(99) < 15) begin
               send_word(REQ_APPEND, $signed(16'($urandom)), $signed(16'($urandom)));
            end else begin
               ang = 6.2831853 * (vert_count + $urandom_range(99) / 100.0) / 64.0;
               rad = 2000.0 + $urandom_range(26000);
               send_word(REQ_APPEND, clamp16(rad * $cos(ang)), clamp16(rad * $sin(ang)));
            end
         end else begin
            send_query();
         end
      end
      start <= 1'b0;
      @(posedge clock);

      while (words_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Covered %0d appends and %0d distance queries, store filled to %0d vertices,",
               append_count, query_count, vert_count);
      $display("with empty, single-vertex, degenerate-edge and store-full cases and idle phases.");
      if (fail_count == 0) begin
         $display("polygon_signed_distance: match");
      end else begin
         $display("polygon_signed_distance: mismatch");
      end
      $finish;
   end

endmodule
